/* sv/rtti_pkg.sv */
package rtti_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned BASE_W     = 6;
    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
    localparam logic [BASE_W-1:0] BASE_ONE  = BASE_W'(1);
    localparam logic [BASE_W-1:0] BASE_OCT  = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(36);

    localparam logic [BASE_W-1:0] RADIX_RESET = BASE_DEC;

    // queue between the classifier and the back end
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX    = 1'b0,
        REG_UNSIGNED = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_SKIP      = 3'd0,
        PH_AFTERSIGN = 3'd1,
        PH_ZERO      = 3'd2,
        PH_DIGITS    = 3'd3,
        PH_STOPPED   = 3'd4,
        PH_BADBASE   = 3'd5
    } phase_t;

    // classified byte
    typedef struct packed {
        logic              nul;
        logic              space;
        logic              sign;
        logic              minus;
        logic              zero;
        logic              hex_x;
        logic              dig_ok;
        logic [BASE_W-1:0] dig_val;
    } ch_class_t;

endpackage

/* sv/radix_text_to_int64_core.sv */
// channel   | direction | handshake            | payload
// s_        | in        | s_valid / s_ready    | s_ch (8b string byte, zero ends it)
// m_        | out       | m_valid / m_ready    | m_value, m_end_offset, m_range_error,
//           |           |                      | m_bad_base
// cfg_      | in        | cfg_valid / cfg_ready| cfg_index (0 radix, 1 unsigned_mode),
//           |           |                      | cfg_data
//
// one byte per cycle while the queue is not full; the back end's multiply-add-compare per digit is combinational
// m_valid rises once its zero byte has passed through the queue and been popped into the output register
// synchronous active-low reset: parser state, queue and output valid clear, radix back to 10
// s_ready drops only when the four-entry queue is full; a waiting result stalls the queue
// only once a zero byte reaches its head, bytes ahead of that zero byte keep draining
module radix_text_to_int64_core #(
    parameter int unsigned MAX_POSITION = 65535
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // byte stream in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rtti_pkg::CH_W-1:0]           s_ch,
    // result out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rtti_pkg::VALUE_W-1:0]        m_value,
    output logic [rtti_pkg::OFFSET_W-1:0]       m_end_offset,
    output logic                                m_range_error,
    output logic                                m_bad_base,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtti_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [rtti_pkg::BASE_W-1:0] radix_reg;
    logic                        unsigned_mode_reg;

    rtti_pkg::ch_class_t         in_cls;
    rtti_pkg::ch_class_t         q_item;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        s_xfer;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg         <= rtti_pkg::RADIX_RESET;
            unsigned_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (rtti_pkg::cfg_reg_t'(cfg_index))
                rtti_pkg::REG_RADIX:    radix_reg         <= cfg_data[rtti_pkg::BASE_W-1:0];
                rtti_pkg::REG_UNSIGNED: unsigned_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: classify each byte as it is transferred in
    rtti_classify u_classify (
        .ch  (s_ch),
        .cls (in_cls)
    );

    assign s_ready = !q_full;
    assign s_xfer  = s_valid && s_ready;

    // decouples the front from the accumulator so either side can stall
    rtti_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_xfer),
        .push_item (in_cls),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    // back: parse state machine, accumulator and result register
    rtti_back #(
        .MAX_POSITION (MAX_POSITION)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .radix         (radix_reg),
        .unsigned_mode (unsigned_mode_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_end_offset  (m_end_offset),
        .m_range_error (m_range_error),
        .m_bad_base    (m_bad_base)
    );

endmodule

/* sv/rtti_classify.sv */
module rtti_classify (
    input  logic [rtti_pkg::CH_W-1:0] ch,
    output rtti_pkg::ch_class_t       cls
);

    always_comb begin
        cls         = '0;
        cls.nul     = (ch == 8'h00);
        cls.space   = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
        cls.sign    = (ch == 8'h2B) || (ch == 8'h2D);
        cls.minus   = (ch == 8'h2D);
        cls.zero    = (ch == 8'h30);
        cls.hex_x   = (ch == 8'h78) || (ch == 8'h58);
        if (ch >= 8'h30 && ch <= 8'h39) begin
            cls.dig_ok  = 1'b1;
            cls.dig_val = rtti_pkg::BASE_W'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            cls.dig_ok  = 1'b1;
            cls.dig_val = rtti_pkg::BASE_W'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            cls.dig_ok  = 1'b1;
            cls.dig_val = rtti_pkg::BASE_W'(ch - 8'h37);
        end
    end

endmodule

/* sv/rtti_queue.sv */
module rtti_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rtti_pkg::ch_class_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output rtti_pkg::ch_class_t pop_item
);

    rtti_pkg::ch_class_t mem [rtti_pkg::QDEPTH];

    logic [rtti_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rtti_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rtti_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == rtti_pkg::QCNT_W'(rtti_pkg::QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/rtti_back.sv */
module rtti_back #(
    parameter int unsigned MAX_POSITION = 65535
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  rtti_pkg::ch_class_t               q_item,
    output logic                              q_pop,
    input  logic [rtti_pkg::BASE_W-1:0]       radix,
    input  logic                              unsigned_mode,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rtti_pkg::VALUE_W-1:0]      m_value,
    output logic [rtti_pkg::OFFSET_W-1:0]     m_end_offset,
    output logic                              m_range_error,
    output logic                              m_bad_base
);

    localparam int unsigned POS_W = $clog2(MAX_POSITION + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_POSITION);
    localparam int unsigned PROD_W = rtti_pkg::VALUE_W + rtti_pkg::BASE_W;

    rtti_pkg::phase_t                 phase_reg, phase_next, ph;
    logic [rtti_pkg::VALUE_W-1:0]     acc_reg, acc_next;
    logic                             minus_reg, minus_next;
    logic [rtti_pkg::BASE_W-1:0]      ebase_reg, ebase_next, eb;
    logic [POS_W-1:0]                 cpos_reg, cpos_next, pos_inc;
    logic [POS_W-1:0]                 epos_reg, epos_next;
    logic                             sat_reg, sat_next;
    logic                             go;
    logic [rtti_pkg::VALUE_W-1:0]     limit;
    logic [PROD_W-1:0]                prod;
    logic [PROD_W:0]                  sum;
    logic [31:0]                      epos_wide;

    logic                             m_valid_reg;
    logic [rtti_pkg::VALUE_W-1:0]     value_reg;
    logic [rtti_pkg::OFFSET_W-1:0]    offset_reg;
    logic                             range_reg;
    logic                             bad_reg;

    // a terminator needs the output slot, other bytes never wait
    assign q_pop = q_valid && (!q_item.nul || !m_valid_reg || m_ready);

    assign pos_inc = (cpos_reg < MAX_POS) ? cpos_reg + 1'b1 : MAX_POS;

    always_comb begin
        if (unsigned_mode) begin
            limit = '1;
        end else if (minus_reg) begin
            limit = {1'b1, {(rtti_pkg::VALUE_W-1){1'b0}}};
        end else begin
            limit = {1'b0, {(rtti_pkg::VALUE_W-1){1'b1}}};
        end
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        ebase_next = ebase_reg;
        cpos_next  = cpos_reg;
        epos_next  = epos_reg;
        sat_next   = sat_reg;
        ph         = phase_reg;
        eb         = ebase_reg;
        go         = 1'b1;
        prod       = '0;
        sum        = '0;
        if (q_pop) begin
            if (q_item.nul) begin
                phase_next = rtti_pkg::PH_SKIP;
                acc_next   = '0;
                minus_next = 1'b0;
                ebase_next = '0;
                cpos_next  = '0;
                epos_next  = '0;
                sat_next   = 1'b0;
            end else begin
                // base is latched on the first byte of a string
                if (phase_reg == rtti_pkg::PH_SKIP && cpos_reg == '0) begin
                    eb = radix;
                    if (radix == rtti_pkg::BASE_ONE || radix > rtti_pkg::BASE_MAX) begin
                        ph = rtti_pkg::PH_BADBASE;
                    end
                end
                cpos_next = pos_inc;
                if (ph == rtti_pkg::PH_SKIP) begin
                    if (q_item.space) begin
                        epos_next = pos_inc;
                        go        = 1'b0;
                    end else if (q_item.sign) begin
                        minus_next = q_item.minus;
                        epos_next  = pos_inc;
                        ph         = rtti_pkg::PH_AFTERSIGN;
                        go         = 1'b0;
                    end else begin
                        ph = rtti_pkg::PH_AFTERSIGN;
                    end
                end
                if (go && ph == rtti_pkg::PH_AFTERSIGN) begin
                    if ((eb == rtti_pkg::BASE_AUTO || eb == rtti_pkg::BASE_HEX)
                        && q_item.zero) begin
                        epos_next = pos_inc;
                        ph        = rtti_pkg::PH_ZERO;
                        go        = 1'b0;
                    end else begin
                        if (eb == rtti_pkg::BASE_AUTO) begin
                            eb = rtti_pkg::BASE_DEC;
                        end
                        ph = rtti_pkg::PH_DIGITS;
                    end
                end
                if (go && ph == rtti_pkg::PH_ZERO) begin
                    if (q_item.hex_x) begin
                        eb        = rtti_pkg::BASE_HEX;
                        epos_next = pos_inc;
                        ph        = rtti_pkg::PH_DIGITS;
                        go        = 1'b0;
                    end else begin
                        if (eb == rtti_pkg::BASE_AUTO) begin
                            eb = rtti_pkg::BASE_OCT;
                        end
                        ph = rtti_pkg::PH_DIGITS;
                    end
                end
                if (go && ph == rtti_pkg::PH_DIGITS) begin
                    if (q_item.dig_ok && q_item.dig_val < eb) begin
                        // exact overflow test: acc * base + digit against the limit
                        prod = PROD_W'(acc_reg) * PROD_W'(eb);
                        sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(q_item.dig_val);
                        if (acc_reg > limit || sum > (PROD_W+1)'(limit)) begin
                            acc_next = limit;
                            sat_next = 1'b1;
                        end else begin
                            acc_next = sum[rtti_pkg::VALUE_W-1:0];
                        end
                        epos_next = pos_inc;
                    end else begin
                        ph = rtti_pkg::PH_STOPPED;
                    end
                end
                phase_next = ph;
                ebase_next = eb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rtti_pkg::PH_SKIP;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            ebase_reg <= '0;
            cpos_reg  <= '0;
            epos_reg  <= '0;
            sat_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            ebase_reg <= ebase_next;
            cpos_reg  <= cpos_next;
            epos_reg  <= epos_next;
            sat_reg   <= sat_next;
        end
    end

    assign epos_wide = 32'(epos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && q_item.nul) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.nul) begin
            if (phase_reg == rtti_pkg::PH_BADBASE) begin
                value_reg  <= '0;
                offset_reg <= '0;
                range_reg  <= 1'b0;
                bad_reg    <= 1'b1;
            end else begin
                value_reg  <= minus_reg ? ('0 - acc_reg) : acc_reg;
                offset_reg <= epos_wide[rtti_pkg::OFFSET_W-1:0];
                range_reg  <= sat_reg;
                bad_reg    <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value       = value_reg;
    assign m_end_offset  = offset_reg;
    assign m_range_error = range_reg;
    assign m_bad_base    = bad_reg;

endmodule
